>>> sv/srs_pkg.sv
// Shared types and constants for the streaming substring replacer.
package srs_pkg;

    localparam int BYTE_W    = 8;
    localparam int JOB_BYTES = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 4'd0,
        CFG_PATTERN_LENGTH     = 4'd1,
        CFG_REPLACEMENT_BYTES  = 4'd2,
        CFG_REPLACEMENT_LENGTH = 4'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_ONE  = 2'd1,
        SH_PLEN = 2'd2
    } shift_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              out_last;
    } out_item_t;

    typedef struct packed {
        logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                 cnt;
        logic                             has;
        logic                             last;
    } job_t;

endpackage

>>> sv/substring_replace_stream.sv
// Streaming substring replacer top level: config registers, window chain, result emitter.
//
// Input channel s_*: one text byte per transaction, in_last on the final byte.
// Result channel m_*: one byte per transaction; has_byte low marks an empty end
// (the whole text collapsed to nothing), out_last marks the final result of a text.
// Config channel cfg_*: index 0 pattern bytes, 1 pattern length, 2 replacement
// bytes, 3 replacement length. Always ready; write only while the block is idle.
// Latency: with the output chain free, the first result of an input transaction is
// on m_* in the cycle after it is accepted. Throughput: one input byte per cycle
// while each byte gives at most one result; a match emits its replacement at one
// byte per cycle from the output shift chain, and a final transaction flushes up
// to eight held bytes the same way. One complete result job is buffered behind the
// chain, so the input keeps accepting while a result waits; when the receiver
// stalls, s_ready drops once that buffer is occupied.
// Reset clears the window, the output chain and the buffer; the registers return
// to pattern length 1 with all other fields zero.
module substring_replace_stream #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  srs_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output srs_pkg::out_item_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]     cfg_data
);
    import srs_pkg::*;

    logic [CFG_W-1:0] pat_bytes_reg, pat_bytes_next;
    logic [LEN_W-1:0] pat_len_reg, pat_len_next;
    logic [CFG_W-1:0] rep_bytes_reg, rep_bytes_next;
    logic [LEN_W-1:0] rep_len_reg, rep_len_next;

    logic accept;
    job_t job;
    logic job_valid;
    logic job_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = job_ready;
    assign accept    = s_valid && s_ready;

    always_comb begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        rep_bytes_next = rep_bytes_reg;
        rep_len_next   = rep_len_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PATTERN_BYTES:      pat_bytes_next = cfg_data;
                CFG_PATTERN_LENGTH:     pat_len_next   = cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  rep_bytes_next = cfg_data;
                CFG_REPLACEMENT_LENGTH: rep_len_next   = cfg_data[LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end else begin
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
            rep_bytes_reg <= rep_bytes_next;
            rep_len_reg   <= rep_len_next;
        end
    end

    srs_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .accept             (accept),
        .s_item             (s_data),
        .pattern_bytes      (pat_bytes_reg),
        .pattern_length     (pat_len_reg),
        .replacement_bytes  (rep_bytes_reg),
        .replacement_length (rep_len_reg),
        .job                (job),
        .job_valid          (job_valid)
    );

    srs_emitter u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .new_job       (job),
        .new_job_valid (job_valid),
        .job_ready     (job_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

>>> sv/srs_win_cell.sv
// One window cell: holds a text byte, compares it with its pattern byte, shifts.
module srs_win_cell (
    input  logic                      aclk,
    input  logic                      upd,
    input  logic                      push_here,
    input  srs_pkg::shift_t           sel,
    input  logic [srs_pkg::BYTE_W-1:0] in_byte,
    input  logic [srs_pkg::BYTE_W-1:0] nb_one,
    input  logic [srs_pkg::BYTE_W-1:0] nb_plen,
    input  logic [srs_pkg::BYTE_W-1:0] pat_byte,
    output logic [srs_pkg::BYTE_W-1:0] post_byte,
    output logic                      eq
);
    import srs_pkg::*;

    logic [BYTE_W-1:0] byte_reg, byte_next;

    always_comb begin
        post_byte = push_here ? in_byte : byte_reg;
        eq        = (post_byte == pat_byte);
    end

    always_comb begin
        byte_next = byte_reg;
        if (upd) begin
            case (sel)
                SH_NONE: byte_next = post_byte;
                SH_ONE:  byte_next = nb_one;
                SH_PLEN: byte_next = nb_plen;
                default: byte_next = post_byte;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

>>> sv/srs_window.sv
// Window chain, pattern match and per-transaction result job formation.
module srs_window #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  srs_pkg::in_item_t          s_item,
    input  logic [srs_pkg::CFG_W-1:0]  pattern_bytes,
    input  logic [srs_pkg::LEN_W-1:0]  pattern_length,
    input  logic [srs_pkg::CFG_W-1:0]  replacement_bytes,
    input  logic [srs_pkg::LEN_W-1:0]  replacement_length,
    output srs_pkg::job_t              job,
    output logic                       job_valid
);
    import srs_pkg::*;

    localparam int W      = MAX_PATTERN;
    localparam int LIMIT  = (W < JOB_BYTES) ? W : JOB_BYTES;
    localparam int FILL_W = $clog2(W + 1);
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    logic [FILL_W-1:0] fill_reg, fill_next, fill_post;
    logic [LEN_W-1:0]  plen, rlen;
    logic [CMP_W-1:0]  fill_c, plen_c;
    logic              match;
    shift_t            sel;

    logic [BYTE_W-1:0] post [W];
    logic [BYTE_W-1:0] pp   [W+JOB_BYTES];
    logic [W-1:0]      eq;

    // Clamp the configured lengths to what the window supports
    always_comb begin
        if (pattern_length == '0)
            plen = LEN_W'(1);
        else if (pattern_length > LEN_W'(LIMIT))
            plen = LEN_W'(LIMIT);
        else
            plen = pattern_length;
        rlen = (replacement_length > LEN_W'(JOB_BYTES)) ? LEN_W'(JOB_BYTES)
                                                        : replacement_length;
    end

    always_comb begin
        fill_post = (fill_reg < FILL_W'(W)) ? fill_reg + FILL_W'(1) : fill_reg;
        fill_c    = CMP_W'(fill_post);
        plen_c    = CMP_W'(plen);
    end

    genvar j;
    generate
        for (j = 0; j < W + JOB_BYTES; j++) begin : g_pad
            if (j < W) begin : g_live
                assign pp[j] = post[j];
            end else begin : g_zero
                assign pp[j] = '0;
            end
        end

        for (j = 0; j < W; j++) begin : g_cell
            logic [BYTE_W-1:0] pat_b;
            logic [BYTE_W-1:0] nbp;

            if (j < JOB_BYTES) begin : g_pat
                assign pat_b = pattern_bytes[j*BYTE_W +: BYTE_W];
            end else begin : g_nopat
                assign pat_b = '0;
            end

            always_comb begin
                nbp = '0;
                for (int k = 1; k <= LIMIT; k++) begin
                    if (plen == LEN_W'(k))
                        nbp = pp[j+k];
                end
            end

            srs_win_cell u_cell (
                .aclk      (aclk),
                .upd       (accept),
                .push_here (fill_reg == FILL_W'(j)),
                .sel       (sel),
                .in_byte   (s_item.in_byte),
                .nb_one    (pp[j+1]),
                .nb_plen   (nbp),
                .pat_byte  (pat_b),
                .post_byte (post[j]),
                .eq        (eq[j])
            );
        end
    endgenerate

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < LIMIT; k++) begin
            if (LEN_W'(k) < plen && !eq[k])
                match = 1'b0;
        end
    end

    always_comb begin
        sel       = SH_NONE;
        fill_next = fill_reg;
        job       = '0;
        job_valid = 1'b0;
        if (accept) begin
            if (!s_item.in_last) begin
                if (fill_c >= plen_c) begin
                    if (match) begin
                        sel       = SH_PLEN;
                        fill_next = fill_post - FILL_W'(plen);
                        job.bytes = replacement_bytes;
                        job.cnt   = rlen;
                        job.has   = 1'b1;
                        job_valid = (rlen != '0);
                    end else begin
                        sel          = SH_ONE;
                        fill_next    = fill_post - FILL_W'(1);
                        job.bytes[0] = pp[0];
                        job.cnt      = LEN_W'(1);
                        job.has      = 1'b1;
                        job_valid    = 1'b1;
                    end
                end else begin
                    fill_next = fill_post;
                end
            end else begin
                // Flush: empty the window and close the text
                fill_next = '0;
                job_valid = 1'b1;
                job.last  = 1'b1;
                job.has   = 1'b1;
                if (fill_c == plen_c && match) begin
                    job.bytes = replacement_bytes;
                    job.cnt   = rlen;
                end else begin
                    for (int k = 0; k < JOB_BYTES; k++)
                        job.bytes[k] = pp[k];
                    job.cnt = (fill_c > CMP_W'(JOB_BYTES)) ? LEN_W'(JOB_BYTES)
                                                           : LEN_W'(fill_post);
                end
                if (job.cnt == '0) begin
                    job.cnt   = LEN_W'(1);
                    job.has   = 1'b0;
                    job.bytes = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

>>> sv/srs_emit_cell.sv
// One output cell: holds a result byte, loads a job or takes its neighbor's byte.
module srs_emit_cell (
    input  logic                       aclk,
    input  logic                       load,
    input  logic                       shift,
    input  logic [srs_pkg::BYTE_W-1:0] load_byte,
    input  logic [srs_pkg::BYTE_W-1:0] nb_byte,
    output logic [srs_pkg::BYTE_W-1:0] out_byte
);
    import srs_pkg::*;

    logic [BYTE_W-1:0] byte_reg, byte_next;

    always_comb begin
        if (load)
            byte_next = load_byte;
        else if (shift)
            byte_next = nb_byte;
        else
            byte_next = byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign out_byte = byte_reg;

endmodule

>>> sv/srs_emitter.sv
// Result emitter: one skid job plus a shift chain that sends one byte per transaction.
module srs_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  srs_pkg::job_t      new_job,
    input  logic               new_job_valid,
    output logic               job_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output srs_pkg::out_item_t m_data
);
    import srs_pkg::*;

    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             has_reg, has_next;
    logic             last_reg, last_next;
    logic             pend_valid_reg, pend_valid_next;
    job_t             pend_reg, pend_next;
    job_t             src;
    logic             pop, free, load_en;

    logic [BYTE_W-1:0] cell_q [JOB_BYTES];

    assign m_valid   = (cnt_reg != '0);
    assign pop       = m_valid && m_ready;
    assign free      = (cnt_reg == '0) || (cnt_reg == LEN_W'(1) && pop);
    assign src       = pend_valid_reg ? pend_reg : new_job;
    assign load_en   = free && (pend_valid_reg || new_job_valid);
    assign job_ready = !pend_valid_reg;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg) begin
            if (free)
                pend_valid_next = 1'b0;
        end else if (new_job_valid && !free) begin
            // Park the job while the chain is still draining
            pend_valid_next = 1'b1;
            pend_next       = new_job;
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        has_next  = has_reg;
        last_next = last_reg;
        if (load_en) begin
            cnt_next  = src.cnt;
            has_next  = src.has;
            last_next = src.last;
        end else if (pop) begin
            cnt_next = cnt_reg - LEN_W'(1);
        end
    end

    genvar j;
    generate
        for (j = 0; j < JOB_BYTES; j++) begin : g_cell
            logic [BYTE_W-1:0] nb;
            if (j + 1 < JOB_BYTES) begin : g_mid
                assign nb = cell_q[j+1];
            end else begin : g_end
                assign nb = '0;
            end
            srs_emit_cell u_cell (
                .aclk      (aclk),
                .load      (load_en),
                .shift     (pop),
                .load_byte (src.bytes[j]),
                .nb_byte   (nb),
                .out_byte  (cell_q[j])
            );
        end
    endgenerate

    always_comb begin
        m_data.out_byte = cell_q[0];
        m_data.has_byte = has_reg;
        m_data.out_last = last_reg && (cnt_reg == LEN_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        has_reg  <= has_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
    end

endmodule
